@@ rtl/sha_pkg.sv @@
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned DigestWords = 8;
  localparam int unsigned Rounds = 64;
  localparam int unsigned QueueDepth = 4;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_LAST_FULL,
    CMD_LAST_PAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  nbytes;
    word_t       word;
  } cmd_t;

  localparam word_t PadWord = 32'h8000_0000;

  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ rtl/sha_front.sv @@
module sha_front (
  input  logic           [31:0] msg_word,
  input  logic           [2:0]  valid_bytes,
  input  logic                  final_word,
  output sha_pkg::cmd_t         cmd
);
  import sha_pkg::*;

  logic [2:0] nb;

  always_comb begin
    nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    cmd.nbytes = nb;
    cmd.word   = msg_word;
    if (!final_word) begin
      cmd.kind   = CMD_DATA;
      cmd.nbytes = 3'd4;
    end else if (nb == 3'd4) begin
      cmd.kind = CMD_LAST_FULL;
    end else begin
      cmd.kind = CMD_LAST_PAD;
      case (nb)
        3'd1:    cmd.word = {msg_word[31:24], 24'h80_0000};
        3'd2:    cmd.word = {msg_word[31:16], 16'h8000};
        3'd3:    cmd.word = {msg_word[31:8], 8'h80};
        default: cmd.word = PadWord;
      endcase
    end
  end

endmodule

@@ rtl/sha_cmd_queue.sv @@
module sha_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  sha_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd,
  output sha_pkg::cmd_t rd_data,
  output logic          empty
);
  import sha_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == (PtrW+1)'(QueueDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/sha_back.sv @@
module sha_back (
  input  logic          clk,
  input  logic          rst,
  input  sha_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_of_digest,
  output logic          empty,
  input  logic          pop
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PAD,
    S_ZERO,
    S_LENLO,
    S_ROUND,
    S_FINISH,
    S_OUT
  } state_t;

  state_t      state;
  state_t      ret;
  state_t      after;
  word_t       chain [DigestWords];
  word_t       v [DigestWords];
  word_t       win [BlockWords];
  logic [3:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  rnd;
  logic [2:0]  idx;
  word_t       pend;
  logic        push_en;
  word_t       push_w;
  word_t       sched_new;
  word_t       t1;
  word_t       t2;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  always_comb begin
    push_en = 1'b0;
    push_w  = cmd.word;
    after   = state;
    cmd_pop = 1'b0;
    case (state)
      S_COLLECT: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          push_en = 1'b1;
          case (cmd.kind)
            CMD_LAST_FULL: after = S_PAD;
            CMD_LAST_PAD:  after = S_ZERO;
            default:       after = S_COLLECT;
          endcase
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        push_w  = pend;
        after   = S_ZERO;
      end
      S_ZERO: begin
        push_en = 1'b1;
        if (fill == 4'd14) begin
          push_w = bit_len[63:32];
          after  = S_LENLO;
        end else begin
          push_w = '0;
          after  = S_ZERO;
        end
      end
      S_LENLO: begin
        push_en = 1'b1;
        push_w  = bit_len[31:0];
        after   = S_OUT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sched_new = (rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10)) + win[9]
              + (rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3)) + win[0];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + win[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_COLLECT;
      ret     <= S_COLLECT;
      fill    <= '0;
      bit_len <= '0;
      rnd     <= '0;
      idx     <= '0;
      chain   <= InitHash;
    end else begin
      if (cmd_pop) begin
        bit_len <= bit_len + 64'({cmd.nbytes, 3'b000});
        pend    <= PadWord;
      end
      if (push_en) begin
        for (int i = 0; i < BlockWords - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[BlockWords-1] <= push_w;
        fill <= fill + 1'b1;
        if (fill == 4'd15) begin
          state <= S_ROUND;
          ret   <= after;
          rnd   <= '0;
          v     <= chain;
        end else begin
          state <= after;
        end
      end else begin
        case (state)
          S_ROUND: begin
            for (int i = 0; i < BlockWords - 1; i++) begin
              win[i] <= win[i+1];
            end
            win[BlockWords-1] <= sched_new;
            v[7] <= v[6];
            v[6] <= v[5];
            v[5] <= v[4];
            v[4] <= v[3] + t1;
            v[3] <= v[2];
            v[2] <= v[1];
            v[1] <= v[0];
            v[0] <= t1 + t2;
            rnd  <= rnd + 1'b1;
            if (rnd == 6'(Rounds - 1)) begin
              state <= S_FINISH;
            end
          end
          S_FINISH: begin
            for (int i = 0; i < DigestWords; i++) begin
              chain[i] <= chain[i] + v[i];
            end
            state <= ret;
          end
          S_OUT: begin
            if (pop) begin
              idx <= idx + 1'b1;
              if (idx == 3'd7) begin
                chain   <= InitHash;
                fill    <= '0;
                bit_len <= '0;
                state   <= S_COLLECT;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign empty          = (state != S_OUT);
  assign digest_word    = chain[idx];
  assign word_index     = idx;
  assign last_of_digest = (idx == 3'd7);

  a_out_block_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> fill == 4'd0)
    else $error("digest presented with a partial block");

  a_lenlo_closes_block: assert property (@(posedge clk) disable iff (rst)
    state == S_LENLO |-> fill == 4'd15)
    else $error("length word not at end of block");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'(Rounds - 1)) |=> state == S_FINISH)
    else $error("compression did not finish after last round");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_COLLECT && !cmd_empty)
    else $error("command taken outside collect");

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// channel   handshake        payload
// input     push / full      msg_word, valid_bytes, final_word
// result    empty / pop      digest_word, word_index, last_of_digest
//
// each message word enters the back end's block window, and a full block adds 64
// rounds and one chaining add
// the final word adds padding words, the 64-bit length and one or two compressions
// a 4-entry queue lets the input side take words while the back end compresses
// rst is synchronous and returns the chaining value to the initial hash
// the back end holds while a digest waits for pop
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] msg_word,
  input  logic [2:0]  valid_bytes,
  input  logic        final_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_of_digest
);
  import sha_pkg::*;

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  sha_front u_front (
    .msg_word    (msg_word),
    .valid_bytes (valid_bytes),
    .final_word  (final_word),
    .cmd         (in_cmd)
  );

  sha_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (in_cmd),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  sha_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd            (q_cmd),
    .cmd_empty      (q_empty),
    .cmd_pop        (q_pop),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_of_digest (last_of_digest),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
